/* sv/qsrk_pkg.sv */
`default_nettype none
package qsrk_pkg;
  localparam int unsigned DefDepth = 64;
  localparam int unsigned DefKeyBits = 32;
  localparam int unsigned KeyW = 32;
  localparam int unsigned TagW = 6;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_POP,
    ST_POPW,
    ST_PIV,
    ST_PIVW,
    ST_CMP,
    ST_SWP,
    ST_SWP2,
    ST_FIN,
    ST_FIN1,
    ST_FIN2,
    ST_PUSHR,
    ST_PUSHL,
    ST_OUTRD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [KeyW-1:0] sort_key;
    logic [TagW-1:0] record_tag;
    logic            last_in;
  } rec_in_t;

  typedef struct packed {
    logic [KeyW-1:0] sorted_key;
    logic [TagW-1:0] sorted_tag;
    logic            last_out;
  } rec_out_t;
endpackage
`default_nettype wire

/* sv/qsrk_in_if.sv */
`default_nettype none
interface qsrk_in_if;
  logic              valid;
  logic              ready;
  qsrk_pkg::rec_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* sv/qsrk_out_if.sv */
`default_nettype none
interface qsrk_out_if;
  logic               valid;
  logic               ready;
  qsrk_pkg::rec_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* sv/qsrk_ram.sv */
`default_nettype none
module qsrk_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* sv/quicksort_record_keys.sv */
// steps: records load one per cycle; each sorted range is popped from the stack
// (not the first), its pivot is fetched, each record is compared, records that
// move are swapped, the pivot is placed unless already in place and the subranges
// are pushed; an empty stack check then leads on to reading out the results
// throughput: one set at a time, then one result per cycle while out ready is high;
// input is ready again once the final result sits in the output register
`default_nettype none
module quicksort_record_keys #(
  parameter int unsigned DEPTH    = qsrk_pkg::DefDepth,
  parameter int unsigned KEY_BITS = qsrk_pkg::DefKeyBits
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic cfg_wdata_i,
  qsrk_in_if.sink   in_if,
  qsrk_out_if.source out_if
);
  import qsrk_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned RW = KEY_BITS + TagW;
  localparam int unsigned SW = 2 * AW;

  state_e state_q, state_d;
  logic desc_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] lo_q, lo_d, hi_q, hi_d, j_q, j_d, nx_q, nx_d;
  logic [CW-1:0] sp_q, sp_d;
  logic [RW-1:0] piv_q, piv_d, rj_q, rj_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rdata;
  logic          stk_we;
  logic [AW-1:0] stk_waddr, stk_raddr;
  logic [SW-1:0] stk_wdata, stk_rdata;
  rec_out_t      out_q, out_d;
  logic          ov_q, ov_d;

  qsrk_ram #(.Width(RW), .Depth(DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // pending ranges, lo in the upper half
  qsrk_ram #(.Width(SW), .Depth(DEPTH)) u_stk_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  logic signed [KEY_BITS-1:0] kv, kp;
  logic take;
  assign kv = rdata[RW-1 -: KEY_BITS];
  assign kp = piv_q[RW-1 -: KEY_BITS];
  assign take = desc_q ? (kv > kp) : (kv < kp);

  logic [KEY_BITS-1:0] in_key;
  if (KEY_BITS > KeyW) begin : g_in_ext
    assign in_key = KEY_BITS'($signed(in_if.payload.sort_key));
  end else begin : g_in_trunc
    assign in_key = in_if.payload.sort_key[KEY_BITS-1:0];
  end

  logic [KeyW-1:0] o_key;
  if (KEY_BITS >= KeyW) begin : g_out_trunc
    assign o_key = rdata[TagW +: KeyW];
  end else begin : g_out_ext
    assign o_key = KeyW'(rdata[RW-1 -: KEY_BITS]);
  end

  assign in_if.ready = (state_q == ST_LOAD);
  assign out_if.valid = ov_q;
  assign out_if.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q <= 1'b1;
    end else if (cfg_we_i) begin
      desc_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      sp_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sp_q    <= sp_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    j_q   <= j_d;
    nx_q  <= nx_d;
    piv_q <= piv_d;
    rj_q  <= rj_d;
    out_q <= out_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    sp_d = sp_q;
    lo_d = lo_q;
    hi_d = hi_q;
    j_d = j_q;
    nx_d = nx_q;
    piv_d = piv_q;
    rj_d = rj_q;
    out_d = out_q;
    ov_d = ov_q;
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    stk_we = 1'b0;
    stk_waddr = '0;
    stk_wdata = '0;
    stk_raddr = '0;
    if (ov_q && out_if.ready) begin
      ov_d = 1'b0;
    end
    case (state_q)
      ST_LOAD: begin
        if (in_if.valid) begin
          if (cnt_q < CW'(DEPTH)) begin
            we = 1'b1;
            waddr = cnt_q[AW-1:0];
            wdata = {in_key, in_if.payload.record_tag};
            cnt_d = cnt_q + CW'(1);
          end
          if (in_if.payload.last_in) begin
            if (cnt_d >= CW'(2)) begin
              lo_d = '0;
              hi_d = AW'(cnt_d - CW'(1));
              state_d = ST_PIV;
            end else begin
              j_d = '0;
              state_d = ST_OUTRD;
            end
          end
        end
      end
      ST_POP: begin
        if (sp_q == '0) begin
          j_d = '0;
          state_d = ST_OUTRD;
        end else begin
          sp_d = sp_q - CW'(1);
          stk_raddr = AW'(sp_q - CW'(1));
          state_d = ST_POPW;
        end
      end
      ST_POPW: begin
        lo_d = stk_rdata[SW-1 -: AW];
        hi_d = stk_rdata[AW-1:0];
        state_d = ST_PIV;
      end
      ST_PIV: begin
        raddr = hi_q;
        j_d = lo_q;
        nx_d = lo_q;
        state_d = ST_PIVW;
      end
      ST_PIVW: begin
        piv_d = rdata;
        raddr = j_q;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (take && nx_q != j_q) begin
          rj_d = rdata;
          raddr = nx_q;
          state_d = ST_SWP;
        end else begin
          if (take) begin
            nx_d = nx_q + AW'(1);
          end
          if (j_q + AW'(1) == hi_q) begin
            state_d = ST_FIN;
          end else begin
            j_d = j_q + AW'(1);
            raddr = j_q + AW'(1);
          end
        end
      end
      ST_SWP: begin
        we = 1'b1;
        waddr = j_q;
        wdata = rdata;
        state_d = ST_SWP2;
      end
      ST_SWP2: begin
        we = 1'b1;
        waddr = nx_q;
        wdata = rj_q;
        nx_d = nx_q + AW'(1);
        if (j_q + AW'(1) == hi_q) begin
          state_d = ST_FIN;
        end else begin
          j_d = j_q + AW'(1);
          raddr = j_q + AW'(1);
          state_d = ST_CMP;
        end
      end
      ST_FIN: begin
        if (nx_q == hi_q) begin
          state_d = ST_PUSHR;
        end else begin
          raddr = nx_q;
          state_d = ST_FIN1;
        end
      end
      ST_FIN1: begin
        we = 1'b1;
        waddr = hi_q;
        wdata = rdata;
        state_d = ST_FIN2;
      end
      ST_FIN2: begin
        we = 1'b1;
        waddr = nx_q;
        wdata = piv_q;
        state_d = ST_PUSHR;
      end
      ST_PUSHR: begin
        if (CW'(nx_q) + CW'(1) < CW'(hi_q)) begin
          stk_we = 1'b1;
          stk_waddr = AW'(sp_q);
          stk_wdata = {nx_q + AW'(1), hi_q};
          sp_d = sp_q + CW'(1);
        end
        state_d = ST_PUSHL;
      end
      ST_PUSHL: begin
        if (CW'(nx_q) > CW'(lo_q) + CW'(1)) begin
          stk_we = 1'b1;
          stk_waddr = AW'(sp_q);
          stk_wdata = {lo_q, nx_q - AW'(1)};
          sp_d = sp_q + CW'(1);
        end
        state_d = ST_POP;
      end
      ST_OUTRD: begin
        raddr = j_q;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        raddr = j_q;
        if (!ov_q || out_if.ready) begin
          ov_d = 1'b1;
          out_d.sorted_key = o_key;
          out_d.sorted_tag = rdata[TagW-1:0];
          out_d.last_out = (CW'(j_q) + CW'(1) == cnt_q);
          if (CW'(j_q) + CW'(1) == cnt_q) begin
            cnt_d = '0;
            state_d = ST_LOAD;
          end else begin
            j_d = j_q + AW'(1);
            raddr = j_q + AW'(1);
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

`ifndef SYNTHESIS
  a_no_in_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> !in_if.ready) else $error("ready outside load");
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= CW'(DEPTH)) else $error("range stack overflow");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH)) else $error("count overflow");
`endif
endmodule
`default_nettype wire

/* dv/testbench.sv */
`default_nettype none
module testbench;
  import qsrk_pkg::*;

  localparam int unsigned Depth = 64;
  localparam int unsigned LimitCycles = 3000000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  qsrk_in_if in_ch ();
  qsrk_out_if out_ch ();

  quicksort_record_keys dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_ch.sink),
    .out_if     (out_ch.source)
  );

  rec_in_t  pending_recs[$];
  rec_out_t sorted_expect[$];
  logic [KeyW-1:0] set_keys[Depth];
  logic [TagW-1:0] set_tags[Depth];
  int unsigned set_fill = 0;
  logic sort_desc;
  int unsigned err_count = 0;
  int unsigned recs_queued;
  int unsigned recs_sent = 0;
  int unsigned recs_seen = 0;
  int unsigned sets_done = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap;
  int unsigned recv_gap;
  bit hold_send;
  bit stim_done;
  bit in_fire;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit key_ahead(logic [KeyW-1:0] a, logic [KeyW-1:0] b);
    if (sort_desc) return $signed(a) > $signed(b);
    return $signed(a) < $signed(b);
  endfunction

  task automatic swap_recs(int unsigned a, int unsigned b);
    logic [KeyW-1:0] tk;
    logic [TagW-1:0] tt;
    tk = set_keys[a];
    tt = set_tags[a];
    set_keys[a] = set_keys[b];
    set_tags[a] = set_tags[b];
    set_keys[b] = tk;
    set_tags[b] = tt;
  endtask

  // lomuto quicksort with an explicit range stack, then queue the results
  task automatic sort_and_expect();
    int unsigned lo_stk[$];
    int unsigned hi_stk[$];
    int unsigned lo, hi, nxt;
    rec_out_t r;
    if (set_fill >= 2) begin
      lo_stk.insert(lo_stk.size(), 0);
      hi_stk.insert(hi_stk.size(), set_fill - 1);
    end
    while (lo_stk.size() > 0) begin
      lo = lo_stk.pop_back();
      hi = hi_stk.pop_back();
      nxt = lo;
      for (int unsigned j = lo; j < hi; j++) begin
        if (key_ahead(set_keys[j], set_keys[hi])) begin
          swap_recs(nxt, j);
          nxt++;
        end
      end
      swap_recs(nxt, hi);
      if (nxt + 1 < hi) begin
        lo_stk.insert(lo_stk.size(), nxt + 1);
        hi_stk.insert(hi_stk.size(), hi);
      end
      if (nxt > lo + 1) begin
        lo_stk.insert(lo_stk.size(), lo);
        hi_stk.insert(hi_stk.size(), nxt - 1);
      end
    end
    for (int unsigned k = 0; k < set_fill; k++) begin
      r.sorted_key = set_keys[k];
      r.sorted_tag = set_tags[k];
      r.last_out = (k + 1 == set_fill);
      sorted_expect.insert(sorted_expect.size(), r);
    end
    set_fill = 0;
    sets_done++;
  endtask

  task automatic accept_rec(rec_in_t rec);
    if (set_fill < Depth) begin
      set_keys[set_fill] = rec.sort_key;
      set_tags[set_fill] = rec.record_tag;
      set_fill++;
    end
    if (rec.last_in) sort_and_expect();
  endtask

  task automatic queue_rec(rec_in_t rec);
    pending_recs.insert(pending_recs.size(), rec);
    recs_queued++;
  endtask

  function automatic logic [KeyW-1:0] rand_key();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 3);
      3: return 32'hffff_fffe + $urandom_range(0, 1);
      default: return $urandom();
    endcase
  endfunction

  task automatic add_set(int unsigned n, bit few_keys);
    rec_in_t rec;
    for (int unsigned i = 0; i < n; i++) begin
      rec.sort_key = few_keys ? 32'($urandom_range(0, 3)) - 32'd1 : rand_key();
      rec.record_tag = TagW'($urandom());
      rec.last_in = (i + 1 == n);
      queue_rec(rec);
    end
  endtask

  task automatic wait_idle();
    while (recs_sent != recs_queued || sorted_expect.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_desc(bit val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sort_desc = val;
  endtask

  initial begin
    rec_in_t rec;
    int unsigned n;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    sort_desc = 1'b1;
    stim_done = 1'b0;
    hold_send = 1'b0;
    recs_queued = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, single record, ties and reverse order
    rec = '{sort_key: 32'h8000_0000, record_tag: 6'h3f, last_in: 1'b0};
    queue_rec(rec);
    rec = '{sort_key: 32'h7fff_ffff, record_tag: 6'h00, last_in: 1'b0};
    queue_rec(rec);
    rec = '{sort_key: 32'h0000_0000, record_tag: 6'h15, last_in: 1'b0};
    queue_rec(rec);
    rec = '{sort_key: 32'hffff_ffff, record_tag: 6'h2a, last_in: 1'b1};
    queue_rec(rec);
    rec = '{sort_key: 32'h0000_0005, record_tag: 6'h01, last_in: 1'b1};
    queue_rec(rec);
    for (int unsigned i = 0; i < 6; i++) begin
      rec = '{sort_key: 32'd7, record_tag: TagW'(i), last_in: i == 5};
      queue_rec(rec);
    end
    wait_idle();
    write_desc(1'b0);
    for (int unsigned i = 0; i < 8; i++) begin
      rec = '{sort_key: 32'(8 - i), record_tag: TagW'(i + 8), last_in: i == 7};
      queue_rec(rec);
    end
    add_set(4, 1'b1);
    wait_idle();

    // overflow: more than the store holds, last mark on a dropped record
    write_desc(1'b1);
    add_set(Depth + 3, 1'b0);
    wait_idle();
    write_desc(1'b0);
    add_set(20, 1'b1);
    wait_idle();

    // random sets, mostly small, config flipped between phases
    for (int unsigned ph = 0; ph < 4; ph++) begin
      write_desc(ph[0]);
      for (int unsigned s = 0; s < 3; s++) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
        add_set(n, $urandom_range(0, 2) == 0);
      end
      if (ph == 2) begin
        hold_send = 1'b1;
        while (sorted_expect.size() > 0 || recs_sent == 0) @(posedge clk_i);
        hold_send = 1'b0;
      end
      wait_idle();
    end
    stim_done = 1'b1;
  end

  // driver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.payload <= '0;
      send_gap <= 0;
    end else if (in_ch.valid && !in_fire) begin
      // hold the waiting transaction
    end else if (hold_send || pending_recs.size() == 0) begin
      in_ch.valid <= 1'b0;
    end else if (send_gap > 0) begin
      in_ch.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else begin
      in_ch.valid <= 1'b1;
      in_ch.payload <= pending_recs.pop_front();
      send_gap <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_ch.valid && in_ch.ready;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      accept_rec(in_ch.payload);
      recs_sent++;
    end
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      recv_gap <= 0;
    end else if (recv_gap > 0) begin
      out_ch.ready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else begin
      out_ch.ready <= 1'b1;
      recv_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rec_out_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      recs_seen++;
      if (sorted_expect.size() == 0) begin
        $error("result with nothing expected: key %0d tag %0d", $signed(got.sorted_key),
               got.sorted_tag);
        err_count++;
      end else begin
        want = sorted_expect.pop_front();
        if (got.sorted_key !== want.sorted_key) begin
          $error("sorted_key expected %0d actual %0d", $signed(want.sorted_key),
                 $signed(got.sorted_key));
          err_count++;
        end
        if (got.sorted_tag !== want.sorted_tag) begin
          $error("sorted_tag expected %0d actual %0d", want.sorted_tag, got.sorted_tag);
          err_count++;
        end
        if (got.last_out !== want.last_out) begin
          $error("last_out expected %0d actual %0d", want.last_out, got.last_out);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LimitCycles) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end else if (stim_done) begin
      $display("sent %0d records in %0d sets, checked %0d sorted records", recs_sent,
               sets_done, recs_seen);
      $display("covered both orders, ties, extreme keys, overflow and output stalls");
      if (err_count == 0 && sorted_expect.size() == 0) begin
        $display("Regression PASS");
      end else begin
        $display("Regression FAIL");
      end
      $finish;
    end
  end
endmodule
`default_nettype wire

/* filelist.f */
sv/qsrk_pkg.sv
sv/qsrk_in_if.sv
sv/qsrk_out_if.sv
sv/qsrk_ram.sv
sv/quicksort_record_keys.sv
dv/testbench.sv
